// ----- rtl/poly_match_string_kernel_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the polynomial match string kernel.
// ----------------------------------------------------------------------------
`ifndef POLY_MATCH_STRING_KERNEL_CORE_DEFINES_SVH
`define POLY_MATCH_STRING_KERNEL_CORE_DEFINES_SVH

// Checked on every edge outside of reset.
`define PMSK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define PMSK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/pmsk_pkg.sv -----
// ----------------------------------------------------------------------------
// pmsk_pkg
// Shared constants and types of the polynomial match string kernel.
// ----------------------------------------------------------------------------
package pmsk_pkg;

  localparam int MAX_LEN    = 4096;
  localparam int SYM_W      = 16;
  localparam int COUNT_W    = 13;
  localparam int DEG_W      = 5;
  localparam int VAL_W      = 64;
  localparam int PROD_W     = VAL_W + COUNT_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DEG_W;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_POLY_DEGREE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INHOMOGENEOUS = 2'd1;

  localparam logic [DEG_W-1:0] DEGREE_RESET = 5'd2;

  typedef struct packed {
    logic [DEG_W-1:0] poly_degree;
    logic             inhomogeneous;
  } cfg_t;

  // One finished string pair waiting for the power unit.
  typedef struct packed {
    logic [COUNT_W-1:0] base;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ----- rtl/pmsk_fifo.sv -----
// ----------------------------------------------------------------------------
// pmsk_fifo
// Short job queue between the match counter and the power unit.
// ----------------------------------------------------------------------------
module pmsk_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  pmsk_pkg::job_t      wr_job,
  input  logic                rd_en,
  output pmsk_pkg::job_t      rd_job,
  output pmsk_pkg::fifo_stat_t stat
);

  pmsk_pkg::job_t                      entries [pmsk_pkg::FIFO_DEPTH];
  logic [pmsk_pkg::FIFO_PTR_W-1:0]     wr_ptr;
  logic [pmsk_pkg::FIFO_PTR_W-1:0]     rd_ptr;
  logic [pmsk_pkg::FIFO_CNT_W-1:0]     count;
  logic                                do_wr;
  logic                                do_rd;

  assign stat.full  = (count == pmsk_pkg::FIFO_CNT_W'(pmsk_pkg::FIFO_DEPTH));
  assign stat.empty = (count == '0);
  assign do_wr      = wr_en && !stat.full;
  assign do_rd      = rd_en && !stat.empty;
  assign rd_job     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == pmsk_pkg::FIFO_PTR_W'(pmsk_pkg::FIFO_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == pmsk_pkg::FIFO_PTR_W'(pmsk_pkg::FIFO_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/pmsk_front.sv -----
// ----------------------------------------------------------------------------
// pmsk_front
// Counts matching symbol pairs and queues the base of each finished string.
// ----------------------------------------------------------------------------
module pmsk_front (
  input  logic                        clk,
  input  logic                        rst,
  input  pmsk_pkg::cfg_t              cfg,
  input  logic                        push,
  input  logic [pmsk_pkg::SYM_W-1:0]  symbol_a,
  input  logic [pmsk_pkg::SYM_W-1:0]  symbol_b,
  input  logic                        last_pair,
  input  pmsk_pkg::fifo_stat_t        q_stat,
  output logic                        q_wr,
  output pmsk_pkg::job_t              q_job
);

  logic [pmsk_pkg::COUNT_W-1:0] match_count;
  logic [pmsk_pkg::COUNT_W-1:0] match_count_next;
  logic                         accept;

  assign accept = push && !q_stat.full;

  // The counter stops at the maximum string length.
  always_comb begin
    match_count_next = match_count;
    if ((symbol_a == symbol_b) &&
        (match_count < pmsk_pkg::COUNT_W'(pmsk_pkg::MAX_LEN))) begin
      match_count_next = match_count + 1'b1;
    end
  end

  assign q_wr       = accept && last_pair;
  assign q_job.base = match_count_next +
                      pmsk_pkg::COUNT_W'(cfg.inhomogeneous);

  always_ff @(posedge clk) begin
    if (rst) begin
      match_count <= '0;
    end else if (accept) begin
      match_count <= last_pair ? '0 : match_count_next;
    end
  end

endmodule

// ----- rtl/pmsk_back.sv -----
// ----------------------------------------------------------------------------
// pmsk_back
// Iterative saturating power unit with a one-entry result register.
// ----------------------------------------------------------------------------
`include "poly_match_string_kernel_core_defines.svh"

module pmsk_back (
  input  logic                        clk,
  input  logic                        rst,
  input  pmsk_pkg::cfg_t              cfg,
  input  pmsk_pkg::job_t              q_job,
  input  pmsk_pkg::fifo_stat_t        q_stat,
  output logic                        q_rd,
  input  logic                        pop,
  output logic                        empty,
  output logic [pmsk_pkg::VAL_W-1:0]  kernel_value,
  output logic                        overflow
);

  typedef enum logic [1:0] {IDLE, MUL, HOLD} state_t;

  state_t                        state;
  logic [pmsk_pkg::COUNT_W-1:0]  base;
  logic [pmsk_pkg::VAL_W-1:0]    acc;
  logic                          acc_ovf;
  logic [pmsk_pkg::DEG_W-1:0]    remaining;
  logic [pmsk_pkg::DEG_W-1:0]    degree_eff;
  logic [pmsk_pkg::PROD_W-1:0]   prod;
  logic                          out_valid;

  assign degree_eff = (cfg.poly_degree == '0) ? pmsk_pkg::DEG_W'(1) : cfg.poly_degree;
  assign q_rd       = (state == IDLE) && !q_stat.empty;
  assign prod       = pmsk_pkg::PROD_W'(acc) * pmsk_pkg::PROD_W'(base);
  assign empty      = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      // A finished power refills the result register in the cycle it is popped.
      if ((state == HOLD) && (!out_valid || pop)) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (!q_stat.empty) begin
            base      <= q_job.base;
            acc       <= pmsk_pkg::VAL_W'(q_job.base);
            acc_ovf   <= 1'b0;
            remaining <= degree_eff - 1'b1;
            // A base of zero or one is its own power, and so is any base at an effective degree of one.
            if ((q_job.base <= pmsk_pkg::COUNT_W'(1)) || (degree_eff == pmsk_pkg::DEG_W'(1))) begin
              state <= HOLD;
            end else begin
              state <= MUL;
            end
          end
        end
        MUL: begin
          if (prod[pmsk_pkg::PROD_W-1:pmsk_pkg::VAL_W] != '0) begin
            acc     <= '1;
            acc_ovf <= 1'b1;
            state   <= HOLD;
          end else begin
            acc       <= prod[pmsk_pkg::VAL_W-1:0];
            remaining <= remaining - 1'b1;
            if (remaining == pmsk_pkg::DEG_W'(1)) begin
              state <= HOLD;
            end
          end
        end
        HOLD: begin
          if (!out_valid || pop) begin
            kernel_value <= acc;
            overflow     <= acc_ovf;
            state        <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `PMSK_ASSERT(a_mul_has_work, (state == MUL) |-> (remaining != '0), "power unit ran past its degree")
  `PMSK_ASSERT(a_ovf_saturates, (out_valid && overflow) |-> (kernel_value == '1), "overflow without saturation")
  `PMSK_ASSERT(a_take_when_idle, q_rd |=> (state != IDLE), "job taken but power unit stayed idle")
  `PMSK_ASSERT_ALWAYS(a_reset_clears, rst |=> ((state == IDLE) && !out_valid), "reset left the power unit busy")

endmodule

// ----- rtl/poly_match_string_kernel_core.sv -----
// ----------------------------------------------------------------------------
// poly_match_string_kernel_core
// Polynomial match kernel over two word strings streamed as aligned pairs.
//
//   channel   handshake         payload
//   input     push / full       symbol_a, symbol_b, last_pair
//   result    pop / empty       kernel_value, overflow
//   config    cfg_we            cfg_index, cfg_data
//
// One symbol pair is taken per cycle while full is low; the match counter never stalls it.
// A pair marked last queues a job; the power unit then raises its base to
// the degree d, with zero read as one, by one 64x13 multiply per cycle (fewer
// multiplies on overflow or a base of zero or one), before the result is registered.
// full rises only while the two-entry job queue is full; reset is
// synchronous and clears the counter and queue and empties the result register.
// ----------------------------------------------------------------------------
module poly_match_string_kernel_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic [pmsk_pkg::SYM_W-1:0]       symbol_a,
  input  logic [pmsk_pkg::SYM_W-1:0]       symbol_b,
  input  logic                             last_pair,
  output logic                             empty,
  input  logic                             pop,
  output logic [pmsk_pkg::VAL_W-1:0]       kernel_value,
  output logic                             overflow,
  input  logic                             cfg_we,
  input  logic [pmsk_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pmsk_pkg::CFG_DATA_W-1:0]  cfg_data
);

  pmsk_pkg::cfg_t       cfg;
  pmsk_pkg::job_t       wr_job;
  pmsk_pkg::job_t       rd_job;
  pmsk_pkg::fifo_stat_t q_stat;
  logic                 q_wr;
  logic                 q_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.poly_degree   <= pmsk_pkg::DEGREE_RESET;
      cfg.inhomogeneous <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        pmsk_pkg::REG_POLY_DEGREE:   cfg.poly_degree   <= cfg_data;
        pmsk_pkg::REG_INHOMOGENEOUS: cfg.inhomogeneous <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign full = q_stat.full;

  pmsk_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .push      (push),
    .symbol_a  (symbol_a),
    .symbol_b  (symbol_b),
    .last_pair (last_pair),
    .q_stat    (q_stat),
    .q_wr      (q_wr),
    .q_job     (wr_job)
  );

  pmsk_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (q_wr),
    .wr_job (wr_job),
    .rd_en  (q_rd),
    .rd_job (rd_job),
    .stat   (q_stat)
  );

  pmsk_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_job        (rd_job),
    .q_stat       (q_stat),
    .q_rd         (q_rd),
    .pop          (pop),
    .empty        (empty),
    .kernel_value (kernel_value),
    .overflow     (overflow)
  );

endmodule

// ----- tb/poly_match_string_kernel_core_tb.sv -----
// ----------------------------------------------------------------------------
// poly_match_string_kernel_core_tb
// Streams aligned symbol pairs into the kernel core and checks every kernel
// value against a predictor running alongside the design. The predictor
// counts matches, adds the inhomogeneous one and forms the saturating
// power. A short directed table comes first, then a run with a saturated
// match counter, then random strings under changing register settings.
// Both the sender and the receiver stall at random.
// ----------------------------------------------------------------------------
module poly_match_string_kernel_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [pmsk_pkg::VAL_W-1:0] VALUE_MAX = {pmsk_pkg::VAL_W{1'b1}};
  localparam int RANDOM_PAIRS = 1500;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic [pmsk_pkg::VAL_W-1:0] value;
    logic                       ovf;
  } kernel_result_t;

  // One row of the directed stream. A row whose register settings differ
  // from the current ones makes the sender drain and reprogram first.
  typedef struct packed {
    logic [pmsk_pkg::DEG_W-1:0] deg;
    logic                       inh;
    logic [pmsk_pkg::SYM_W-1:0] a;
    logic [pmsk_pkg::SYM_W-1:0] b;
    logic                       last;
    logic                       typed;
    logic [pmsk_pkg::VAL_W-1:0] value;
    logic                       ovf;
  } pair_row_t;

  localparam int NUM_ROWS = 22;

  pair_row_t directed_rows [NUM_ROWS] = '{
    '{5'd2,  1'b0, 16'h0005, 16'h0005, 1'b0, 1'b0, 64'd0, 1'b0},
    '{5'd2,  1'b0, 16'h0007, 16'h0007, 1'b1, 1'b1, 64'd4, 1'b0},
    '{5'd2,  1'b0, 16'h0001, 16'h0002, 1'b1, 1'b1, 64'd0, 1'b0},
    '{5'd2,  1'b0, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 64'd0, 1'b0},
    '{5'd2,  1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 64'd0, 1'b0},
    '{5'd2,  1'b0, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 64'd0, 1'b0},
    '{5'd2,  1'b0, 16'hAAAA, 16'h5555, 1'b0, 1'b0, 64'd0, 1'b0},
    '{5'd2,  1'b0, 16'h0000, 16'hFFFF, 1'b1, 1'b1, 64'd4, 1'b0},
    '{5'd0,  1'b1, 16'h0003, 16'h0003, 1'b1, 1'b1, 64'd2, 1'b0},
    '{5'd0,  1'b1, 16'h0001, 16'h0000, 1'b1, 1'b1, 64'd1, 1'b0},
    '{5'd31, 1'b0, 16'h0004, 16'h0009, 1'b1, 1'b1, 64'd0, 1'b0},
    '{5'd31, 1'b1, 16'h1234, 16'h1234, 1'b0, 1'b0, 64'd0, 1'b0},
    '{5'd31, 1'b1, 16'h8000, 16'h8000, 1'b0, 1'b0, 64'd0, 1'b0},
    '{5'd31, 1'b1, 16'h7FFF, 16'h7FFF, 1'b1, 1'b1, 64'h4000_0000_0000_0000, 1'b0},
    '{5'd31, 1'b1, 16'h0011, 16'h0011, 1'b0, 1'b0, 64'd0, 1'b0},
    '{5'd31, 1'b1, 16'h0022, 16'h0022, 1'b0, 1'b0, 64'd0, 1'b0},
    '{5'd31, 1'b1, 16'h0033, 16'h0033, 1'b0, 1'b0, 64'd0, 1'b0},
    '{5'd31, 1'b1, 16'h0044, 16'h0044, 1'b1, 1'b1, VALUE_MAX, 1'b1},
    '{5'd16, 1'b1, 16'h0009, 16'h0009, 1'b0, 1'b0, 64'd0, 1'b0},
    '{5'd16, 1'b1, 16'h0008, 16'h0008, 1'b1, 1'b0, 64'd0, 1'b0},
    '{5'd1,  1'b0, 16'h0006, 16'h0006, 1'b1, 1'b0, 64'd0, 1'b0},
    '{5'd16, 1'b0, 16'h00FF, 16'h00FE, 1'b1, 1'b1, 64'd0, 1'b0}
  };

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                push = 1'b0;
  logic                                full;
  logic [pmsk_pkg::SYM_W-1:0]          symbol_a = '0;
  logic [pmsk_pkg::SYM_W-1:0]          symbol_b = '0;
  logic                                last_pair = 1'b0;
  logic                                empty;
  logic                                pop = 1'b0;
  logic [pmsk_pkg::VAL_W-1:0]          kernel_value;
  logic                                overflow;
  logic                                cfg_we = 1'b0;
  logic [pmsk_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [pmsk_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

  // Register copies seen by the predictor; they change only while idle.
  logic [pmsk_pkg::DEG_W-1:0]          degree_shadow = pmsk_pkg::DEGREE_RESET;
  logic                                inhom_shadow = 1'b0;
  int unsigned                         match_tally = 0;

  // A typed expectation rides along with the pair that carries it.
  logic                                item_typed = 1'b0;
  logic [pmsk_pkg::VAL_W-1:0]          item_typed_value = '0;
  logic                                item_typed_ovf = 1'b0;

  logic                                calm = 1'b0;
  int unsigned                         fail_count = 0;
  kernel_result_t                      pending_kernels [$];

  poly_match_string_kernel_core DUT (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .symbol_a     (symbol_a),
    .symbol_b     (symbol_b),
    .last_pair    (last_pair),
    .empty        (empty),
    .pop          (pop),
    .kernel_value (kernel_value),
    .overflow     (overflow),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic kernel_result_t kernel_power(logic [pmsk_pkg::VAL_W-1:0] base,
                                                  logic [pmsk_pkg::DEG_W-1:0] deg);
    kernel_result_t r;
    int unsigned    steps;
    r.value = base;
    r.ovf = 1'b0;
    steps = (deg == 0) ? 1 : deg;
    if (base > 1) begin
      for (int k = 1; k < steps; k++) begin
        if (!r.ovf) begin
          if (r.value > VALUE_MAX / base) begin
            r.ovf = 1'b1;
            r.value = VALUE_MAX;
          end else begin
            r.value = r.value * base;
          end
        end
      end
    end
    return r;
  endfunction

  always @(negedge clk) begin
    pop <= calm || ($urandom_range(99) >= 24);
  end

  // Prediction on each accepted pair, checking on each accepted result.
  always @(posedge clk) begin
    kernel_result_t want;
    kernel_result_t got;
    if (!rst) begin
      if (push && !full) begin
        if (symbol_a == symbol_b && match_tally < pmsk_pkg::MAX_LEN)
          match_tally = match_tally + 1;
        if (last_pair) begin
          want = kernel_power(pmsk_pkg::VAL_W'(match_tally + inhom_shadow), degree_shadow);
          if (item_typed) begin
            want.value = item_typed_value;
            want.ovf = item_typed_ovf;
          end
          pending_kernels.push_back(want);
          match_tally = 0;
        end
      end
      if (pop && !empty) begin
        got.value = kernel_value;
        got.ovf = overflow;
        if (pending_kernels.size() == 0) begin
          $display("%0t: unexpected transaction, kernel_value %h overflow %b",
                   $time, got.value, got.ovf);
          fail_count++;
        end else begin
          want = pending_kernels.pop_front();
          if (got.value !== want.value) begin
            $display("%0t: kernel_value expected %h actual %h",
                     $time, want.value, got.value);
            fail_count++;
          end
          if (got.ovf !== want.ovf) begin
            $display("%0t: overflow expected %b actual %b",
                     $time, want.ovf, got.ovf);
            fail_count++;
          end
        end
      end
    end
  end

  task automatic push_pair(input logic [pmsk_pkg::SYM_W-1:0] a,
                           input logic [pmsk_pkg::SYM_W-1:0] b,
                           input logic last, input logic typed,
                           input logic [pmsk_pkg::VAL_W-1:0] value, input logic ovf);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 24) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    symbol_a = a;
    symbol_b = b;
    last_pair = last;
    item_typed = typed;
    item_typed_value = value;
    item_typed_ovf = ovf;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Stop sending and let every expected kernel value come out, then give
  // the power unit time to settle before anything else happens.
  task automatic drain();
    @(negedge clk);
    push = 1'b0;
    while (pending_kernels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [pmsk_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pmsk_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == pmsk_pkg::REG_POLY_DEGREE)
      degree_shadow = data[pmsk_pkg::DEG_W-1:0];
    else if (idx == pmsk_pkg::REG_INHOMOGENEOUS)
      inhom_shadow = data[0];
  endtask

  task automatic set_config(input logic [pmsk_pkg::DEG_W-1:0] deg, input logic inh);
    drain();
    write_reg(pmsk_pkg::REG_POLY_DEGREE, deg);
    write_reg(pmsk_pkg::REG_INHOMOGENEOUS, pmsk_pkg::CFG_DATA_W'(inh));
  endtask

  task automatic random_string(input int unsigned len, input int unsigned match_pct);
    logic [pmsk_pkg::SYM_W-1:0] a;
    logic [pmsk_pkg::SYM_W-1:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      a = pmsk_pkg::SYM_W'($urandom);
      if ($urandom_range(99) < match_pct)
        b = a;
      else if ($urandom_range(1) == 0)
        b = a ^ (pmsk_pkg::SYM_W'(1) << $urandom_range(pmsk_pkg::SYM_W - 1));
      else
        b = pmsk_pkg::SYM_W'($urandom);
      push_pair(a, b, i == len - 1, 1'b0, '0, 1'b0);
    end
  endtask

  initial begin
    int unsigned                sent;
    int unsigned                in_phase;
    int unsigned                len;
    logic [pmsk_pkg::DEG_W-1:0] deg;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int r = 0; r < NUM_ROWS; r++) begin
      if (directed_rows[r].deg != degree_shadow || directed_rows[r].inh != inhom_shadow)
        set_config(directed_rows[r].deg, directed_rows[r].inh);
      push_pair(directed_rows[r].a, directed_rows[r].b, directed_rows[r].last,
                directed_rows[r].typed, directed_rows[r].value, directed_rows[r].ovf);
    end

    // A string longer than the match limit: matches past the limit
    // are dropped, and the inhomogeneous one still lands on top.
    set_config(5'd1, 1'b1);
    random_string(pmsk_pkg::MAX_LEN + 8, 100);

    sent = 0;
    for (int phase = 0; sent < RANDOM_PAIRS; phase++) begin
      calm = (phase == 4 || phase == 5);
      case ($urandom_range(5))
        0: deg = 5'd0;
        1: deg = 5'd1;
        2: deg = 5'd16;
        3: deg = 5'd31;
        default: deg = pmsk_pkg::DEG_W'($urandom_range(31));
      endcase
      set_config(deg, 1'($urandom_range(1)));
      in_phase = 0;
      while (in_phase < 100) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        random_string(len, $urandom_range(30, 100));
        in_phase += len;
      end
      sent += in_phase;
    end
    calm = 1'b0;

    drain();
    if (pending_kernels.size() != 0) begin
      $display("%0t: %0d kernel values never arrived", $time, pending_kernels.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
